@@ src/bsc_pkg.sv @@
// Shared constants and types for the 24-to-8 bit block scaler.
package bsc_pkg;

  localparam int BLOCK_DEPTH = 64;
  localparam int SAMPLE_W    = 24;
  localparam int PEAK_W      = SAMPLE_W - 1;
  localparam int OUT_W       = 8;
  localparam int SHIFT_W     = 5;
  localparam int PEAK_LIMIT  = 128;
  localparam int IDX_W       = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);
  // two banks: one filling while the other drains
  localparam int NUM_BANKS   = 2;
  localparam int RAM_DEPTH   = NUM_BANKS * (2 ** IDX_W);
  localparam int RAM_AW      = IDX_W + 1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] compressed_sample;
    logic [SHIFT_W-1:0]      shift_amount;
    logic                    last_out;
    logic                    overflowed;
  } result_t;

  // one completed block handed from front to back
  typedef struct packed {
    logic               bank;
    logic [CNT_W-1:0]   count;
    logic [SHIFT_W-1:0] shift_amount;
    logic               overflowed;
  } desc_t;

endpackage

@@ src/block_scale_24_to_8.sv @@
// Top level of the block floating-point scaler, 24-bit samples in, 8-bit samples out.
//
//   channel   dir   valid/stall                payload
//   input     in    in_valid_i / in_stall_o    sample_t  (sample_value, last_sample)
//   output    out   out_valid_o / out_stall_i  result_t  (compressed_sample, shift_amount,
//                                                         last_out, overflowed)
//
// Samples are written to the RAM as they are accepted. After the last sample the
// shift search halves the peak once per bit of shift, with the input stalled.
// Each sample is emitted by a RAM read followed by the output register load, and
// the next read waits for that load. Two banks let one block load while the previous drains;
// the input stalls while both banks hold unsent blocks. No clearing pass after reset.
module block_scale_24_to_8 import bsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  sample_t in_data_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_stall_i
);

  logic                q_full, q_empty, push, pop;
  desc_t               push_desc, head;
  logic                ram_we, ram_re;
  logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

  bsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  bsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  bsc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

@@ src/bsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bsc_front.sv @@
// Front end: stores samples, tracks the block peak and finds the block shift.
module bsc_front import bsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  sample_t             in_data_i,
  output logic                in_stall_o,
  input  logic                q_full_i,
  output logic                push_o,
  output desc_t               push_desc_o,
  output logic                ram_we_o,
  output logic [RAM_AW-1:0]   ram_waddr_o,
  output logic [SAMPLE_W-1:0] ram_wdata_o
);

  typedef enum logic [1:0] {
    FS_LOAD = 2'b01,
    FS_NORM = 2'b10
  } front_state_e;

  front_state_e       state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PEAK_W-1:0]  peak_q, peak_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic               drop_q, drop_d;
  logic               bank_q, bank_d;

  logic              accept;
  logic              room;
  logic [PEAK_W-1:0] mag;

  assign in_stall_o = (state_q != FS_LOAD) || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign room       = count_q < CNT_W'(BLOCK_DEPTH);
  // ones' complement of a negative sample keeps the magnitude in 23 bits
  assign mag = in_data_i.sample_value[SAMPLE_W-1] ? ~in_data_i.sample_value[PEAK_W-1:0]
                                                  : in_data_i.sample_value[PEAK_W-1:0];

  assign ram_we_o    = accept && room;
  assign ram_waddr_o = {bank_q, count_q[IDX_W-1:0]};
  assign ram_wdata_o = in_data_i.sample_value;

  assign push_desc_o.bank         = bank_q;
  assign push_desc_o.count        = count_q;
  assign push_desc_o.shift_amount = shift_q;
  assign push_desc_o.overflowed   = drop_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    peak_d  = peak_q;
    shift_d = shift_q;
    drop_d  = drop_q;
    bank_d  = bank_q;
    push_o  = 1'b0;
    case (state_q)
      FS_LOAD: begin
        if (accept) begin
          if (room) begin
            count_d = count_q + CNT_W'(1);
            if (mag > peak_q) begin
              peak_d = mag;
            end
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last_sample) begin
            shift_d = '0;
            state_d = FS_NORM;
          end
        end
      end
      FS_NORM: begin
        // one bit of shift per cycle until the peak fits a signed byte
        if (peak_q >= PEAK_W'(PEAK_LIMIT)) begin
          peak_d  = peak_q >> 1;
          shift_d = shift_q + SHIFT_W'(1);
        end else begin
          push_o  = 1'b1;
          count_d = '0;
          peak_d  = '0;
          drop_d  = 1'b0;
          bank_d  = ~bank_q;
          state_d = FS_LOAD;
        end
      end
      default: begin
        state_d = FS_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_LOAD;
      count_q <= '0;
      peak_q  <= '0;
      shift_q <= '0;
      drop_q  <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      shift_q <= shift_d;
      drop_q  <= drop_d;
      bank_q  <= bank_d;
    end
  end

endmodule

@@ src/bsc_queue.sv @@
// Two-entry block queue between front and back; an entry stays until its block is fully read out.
module bsc_queue import bsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  input  logic  pop_i,
  output desc_t head_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int QCNT_W = $clog2(NUM_BANKS + 1);

  desc_t             entry_q [NUM_BANKS];
  logic              wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(NUM_BANKS);
  assign empty_o = cnt_q == '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

@@ src/bsc_back.sv @@
// Back end: reads a stored block back, scales each sample and holds the output register.
module bsc_back import bsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  desc_t               head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                ram_re_o,
  output logic [RAM_AW-1:0]   ram_raddr_o,
  input  logic [SAMPLE_W-1:0] ram_rdata_i,
  output logic                out_valid_o,
  output result_t             out_data_o,
  input  logic                out_stall_i
);

  typedef enum logic [1:0] {
    BS_READ = 2'b01,
    BS_DATA = 2'b10
  } back_state_e;

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  logic                       load;
  logic                       last;
  logic signed [SAMPLE_W-1:0] scaled;

  assign ram_raddr_o = {head_i.bank, idx_q};
  assign scaled      = $signed(ram_rdata_i) >>> head_i.shift_amount;
  assign last        = (CNT_W'(idx_q) + CNT_W'(1)) == head_i.count;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    ram_re_o = 1'b0;
    load     = 1'b0;
    pop_o    = 1'b0;
    case (state_q)
      BS_READ: begin
        if (!empty_i) begin
          ram_re_o = 1'b1;
          state_d  = BS_DATA;
        end
      end
      BS_DATA: begin
        // read data holds until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = BS_READ;
          if (last) begin
            idx_d = '0;
            pop_o = 1'b1;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = BS_READ;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.compressed_sample <= scaled[OUT_W-1:0];
      out_q.shift_amount      <= head_i.shift_amount;
      out_q.last_out          <= last;
      out_q.overflowed        <= head_i.overflowed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_READ;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/bsc_checker.sv @@
// Port-level checks for the block scaler, bound to the top level.
module bsc_checker import bsc_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input sample_t in_data_i,
  input logic    in_stall_o,
  input logic    out_valid_o,
  input result_t out_data_o,
  input logic    out_stall_i
);

  logic       in_last_xfer, out_last_xfer;
  logic [2:0] pend_q;

  assign in_last_xfer  = in_valid_i && !in_stall_o && in_data_i.last_sample;
  assign out_last_xfer = out_valid_o && !out_stall_i && out_data_o.last_out;

  // blocks closed on input but not yet fully sent; a stalled last transfer in the output register
  // can coexist with a full queue, or with one queued block and a block under shift search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_last_xfer && !out_last_xfer) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_last_xfer && !in_last_xfer) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transfer changed while stalled");

  a_out_has_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0)
    else $error("output valid with no completed block pending");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more than three blocks held");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.shift_amount <= SHIFT_W'(16))
    else $error("block shift out of range");

endmodule

bind block_scale_24_to_8 bsc_checker u_bsc_checker (.*);
